FILE: rtl/actr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// actr_pkg: shared types, codes and AES tables
// S-box, round constants, byte helpers and the pipeline stage record.
// ----------------------------------------------------------------------------
package actr_pkg;

  localparam int BlockBytes = 16;
  localparam int LastByte   = 15;
  localparam int NumRounds  = 14;

  typedef logic [2:0]   cfg_idx_t;
  typedef logic [63:0]  word64_t;
  typedef logic [127:0] blk_t;
  typedef logic [4:0]   cnt_t;

  localparam cfg_idx_t CFG_KEY0    = 3'd0;
  localparam cfg_idx_t CFG_KEY1    = 3'd1;
  localparam cfg_idx_t CFG_KEY2    = 3'd2;
  localparam cfg_idx_t CFG_KEY3    = 3'd3;
  localparam cfg_idx_t CFG_IV_HIGH = 3'd4;
  localparam cfg_idx_t CFG_IV_LOW  = 3'd5;

  // One pipeline stage: cipher state, two consecutive round keys, message, byte count.
  typedef struct packed {
    blk_t state;
    blk_t rk_a;
    blk_t rk_b;
    blk_t data;
    cnt_t cnt;
  } stage_t;

  // Key step control handed to each key schedule stage.
  typedef struct packed {
    logic       rot_en;
    logic [7:0] rcon;
  } kctl_t;

  localparam logic [7:0] RCON [0:7] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
  };

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/actr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// actr_if: stream channels of the counter-mode engine
// Message word channel in, result word channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface actr_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic [4:0]  byte_count;
  logic        first_block;

  modport source (output valid, data_high, data_low, byte_count, first_block,
                  input ready);
  modport sink   (input valid, data_high, data_low, byte_count, first_block,
                  output ready);
endinterface

interface actr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic [4:0]  result_count;

  modport source (output valid, result_high, result_low, result_count,
                  input ready);
  modport sink   (input valid, result_high, result_low, result_count,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/actr_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// actr_round: one AES encryption round
// SubBytes, ShiftRows, MixColumns (skipped on the last round), AddRoundKey.
// ----------------------------------------------------------------------------
module actr_round (
  input  wire  logic          final_rnd,
  input  wire  actr_pkg::blk_t state_i,
  input  wire  actr_pkg::blk_t rk_i,
  output       actr_pkg::blk_t state_o
);
  import actr_pkg::*;

  logic [7:0] s [0:15];
  logic [7:0] t [0:15];
  logic [7:0] m [0:15];

  always_comb begin
    for (int k = 0; k < BlockBytes; k++) begin
      s[k] = state_i[127 - 8 * k -: 8];
    end
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[r + 4 * c] = SBOX[s[r + 4 * ((c + r) % 4)]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] all;
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int k = 0; k < BlockBytes; k++) begin
      state_o[127 - 8 * k -: 8] = (final_rnd ? t[k] : m[k]) ^ rk_i[127 - 8 * k -: 8];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/actr_kstep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// actr_kstep: AES-256 key schedule step
// Derive the next 128-bit round key from the two before it.
// ----------------------------------------------------------------------------
module actr_kstep (
  input  wire  actr_pkg::kctl_t ctl,
  input  wire  actr_pkg::blk_t  rk_a,
  input  wire  actr_pkg::blk_t  rk_b,
  output       actr_pkg::blk_t  rk_o
);
  import actr_pkg::*;

  logic [31:0] last, tmp, n0, n1, n2, n3;

  always_comb begin
    last = rk_b[31:0];
    if (ctl.rot_en) begin
      tmp = sub_word({last[23:0], last[31:24]}) ^ {ctl.rcon, 24'h000000};
    end else begin
      tmp = sub_word(last);
    end
    n0   = rk_a[127:96] ^ tmp;
    n1   = rk_a[95:64]  ^ n0;
    n2   = rk_a[63:32]  ^ n1;
    n3   = rk_a[31:0]   ^ n2;
    rk_o = {n0, n1, n2, n3};
  end

endmodule

`default_nettype wire

FILE: rtl/aes256_ctr_keystream_xor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes256_ctr_keystream_xor_top: AES-256 counter-mode engine
// Encrypts a running counter and XORs the keystream into message words.
// ----------------------------------------------------------------------------
// Usage:
//   Load the key (four 64-bit words) and the IV (two words) through the cfg
//   write port while the engine is idle. Each in_ch word carries up to 16
//   message bytes, the count of valid leading bytes and a first_block flag
//   that reloads the counter from the IV before the word is used.
//   Each out_ch word holds the XORed bytes, bytes past the count zeroed,
//   and the clamped count (0 reads as 1, above 16 as 16).
//   The input stage adds the first round key, then one AES round per stage,
//   the last round landing in the output register, with the round keys
//   derived alongside the state in the same stages. Throughput is one word
//   per cycle while out_ch does not stall.
//   The counter advances on each accepted word, as a 128-bit big-endian
//   value that wraps.
//   When out_ch stalls, the whole pipeline holds and in_ch.ready drops.
//   Reset clears key, IV, counter and all stage valid bits.
// ----------------------------------------------------------------------------
module aes256_ctr_keystream_xor_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire actr_pkg::cfg_idx_t cfg_index,
  input  wire actr_pkg::word64_t  cfg_data,
  actr_in_if.sink                 in_ch,
  actr_out_if.source              out_ch
);
  import actr_pkg::*;

  localparam int Stages = NumRounds;

  // Configuration and counter
  word64_t key_r [0:3];
  word64_t iv_hi_r, iv_lo_r;
  blk_t    ctr_r;
  blk_t    ctr_cur;

  // Pipeline
  stage_t            st_r   [0:Stages-1];
  stage_t            st_nxt [0:Stages-2];
  stage_t            s0_nxt;
  logic [Stages-1:0] vld_r;
  logic              ov_r;
  logic              adv;
  logic              in_acc;
  blk_t              ks_fin;
  blk_t              res_nxt;
  blk_t              res_r;
  cnt_t              cnt_r;
  cnt_t              cnt_in;

  // Advance everything when the output slot is free or being drained.
  assign adv          = !ov_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign in_acc       = in_ch.valid && adv;
  assign out_ch.valid = ov_r;
  assign out_ch.result_high  = res_r[127:64];
  assign out_ch.result_low   = res_r[63:0];
  assign out_ch.result_count = cnt_r;

  // Stage 0: pick the counter, clamp the count, add the first round key.
  always_comb begin
    ctr_cur = in_ch.first_block ? {iv_hi_r, iv_lo_r} : ctr_r;
    if (in_ch.byte_count == 5'd0) begin
      cnt_in = 5'd1;
    end else if (in_ch.byte_count > cnt_t'(BlockBytes)) begin
      cnt_in = cnt_t'(BlockBytes);
    end else begin
      cnt_in = in_ch.byte_count;
    end
    s0_nxt.rk_a  = {key_r[0], key_r[1]};
    s0_nxt.rk_b  = {key_r[2], key_r[3]};
    s0_nxt.state = ctr_cur ^ {key_r[0], key_r[1]};
    s0_nxt.data  = {in_ch.data_high, in_ch.data_low};
    s0_nxt.cnt   = cnt_in;
  end

  // Rounds 1..13 with the key schedule riding along.
  for (genvar j = 0; j < Stages - 1; j++) begin : g_rnd
    localparam int Tgt = j + 2;
    kctl_t kc;
    assign kc.rot_en = (Tgt % 2) == 0;
    assign kc.rcon   = RCON[Tgt / 2];

    actr_round u_round (
      .final_rnd (1'b0),
      .state_i   (st_r[j].state),
      .rk_i      (st_r[j].rk_b),
      .state_o   (st_nxt[j].state)
    );

    actr_kstep u_kstep (
      .ctl  (kc),
      .rk_a (st_r[j].rk_a),
      .rk_b (st_r[j].rk_b),
      .rk_o (st_nxt[j].rk_b)
    );

    assign st_nxt[j].rk_a = st_r[j].rk_b;
    assign st_nxt[j].data = st_r[j].data;
    assign st_nxt[j].cnt  = st_r[j].cnt;
  end

  // Round 14, then XOR into the message and drop bytes past the count.
  actr_round u_round_last (
    .final_rnd (1'b1),
    .state_i   (st_r[Stages-1].state),
    .rk_i      (st_r[Stages-1].rk_b),
    .state_o   (ks_fin)
  );

  always_comb begin
    for (int k = 0; k < BlockBytes; k++) begin
      if (k < int'(st_r[Stages-1].cnt)) begin
        res_nxt[127 - 8 * k -: 8] = st_r[Stages-1].data[127 - 8 * k -: 8]
                                   ^ ks_fin[127 - 8 * k -: 8];
      end else begin
        res_nxt[127 - 8 * k -: 8] = 8'h00;
      end
    end
  end

  // Control and configuration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      ov_r    <= 1'b0;
      ctr_r   <= '0;
      iv_hi_r <= '0;
      iv_lo_r <= '0;
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
    end else begin
      if (adv) begin
        vld_r <= {vld_r[Stages-2:0], in_ch.valid};
        ov_r  <= vld_r[Stages-1];
      end
      if (in_acc) begin
        ctr_r <= ctr_cur + 128'd1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY0:    key_r[0] <= cfg_data;
          CFG_KEY1:    key_r[1] <= cfg_data;
          CFG_KEY2:    key_r[2] <= cfg_data;
          CFG_KEY3:    key_r[3] <= cfg_data;
          CFG_IV_HIGH: iv_hi_r  <= cfg_data;
          CFG_IV_LOW:  iv_lo_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload: hold on stall, no reset.
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= s0_nxt;
      for (int j = 0; j < Stages - 1; j++) begin
        st_r[j+1] <= st_nxt[j];
      end
      res_r <= res_nxt;
      cnt_r <= st_r[Stages-1].cnt;
    end
  end

`ifndef SYNTHESIS
  // Counter reloads from the IV on a first word, else steps by one.
  a_ctr_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.first_block) |=> (ctr_r == ({$past(iv_hi_r), $past(iv_lo_r)} + 128'd1)))
    else $error("counter not reloaded from IV");
  a_ctr_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.first_block) |=> (ctr_r == $past(ctr_r) + 128'd1))
    else $error("counter did not advance by one");
  a_ctr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(ctr_r))
    else $error("counter moved without an accepted word");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (cnt_r != 5'd0 && cnt_r <= 5'd16))
    else $error("result count out of range");
`endif

endmodule

`default_nettype wire
